// File: hw/rtl/gbba_pkg.sv
// types and constants shared by the grouped block bitmap allocator
package gbba_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WIDX_W      = 6;
  localparam int unsigned GWORD_W     = 7;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned MEM_DEPTH   = 1024;
  localparam int unsigned GROUP_BITS  = 8192;
  localparam int unsigned MAX_BLOCKS  = 65536;
  localparam int unsigned MAX_GROUPS  = 8;

  localparam logic [2:0] REG_FIRST_DATA_BLOCK = 3'd0;
  localparam logic [2:0] REG_BLOCKS_COUNT     = 3'd1;
  localparam logic [2:0] REG_BLOCKS_PER_GROUP = 3'd2;
  localparam logic [2:0] REG_GROUPS_COUNT     = 3'd3;
  localparam logic [2:0] REG_INODES_PER_GROUP = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOFREE = 2'd1,
    ST_REJECT = 2'd2,
    ST_BAD    = 2'd3
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_GRP   = 9'b000001000,
    S_NXT   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_FCHK  = 9'b001000000,
    S_FRD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

endpackage

// File: hw/rtl/grouped_block_bitmap_allocator.sv
// grouped bitmap block allocator: group search, bitmap memory and free counts
//
// input stream: tuser carries the operation (0 allocate, 1 free), tdata the
// inode number and the block number. every transaction gives exactly one
// result transaction with the allocated block and a status code.
// configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the block is idle; the block does not enforce it.
// one item is worked on at a time. an allocation takes a start step and
// two passes of the divider (preferred group, then modulo group count, one
// bit a cycle), then a check and a step to the next group per skipped group,
// or a check and a read of each 64-bit bitmap word for a group that is
// scanned, and a step to load the output. a free takes a start step, one
// pass of the shared divider and one read-modify-write.
// after reset the bitmap memory is swept to all used, one word a cycle;
// no input is taken during that sweep. counts reset to zero.
// a finished result waits in an output register; while the receiver stalls
// the block still takes and works on the next transaction, then holds its
// result until the output register frees up.
module grouped_block_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // inode_number [31:0], block_number [47:32]
  input  logic [47:0] s_axis_tdata,
  // func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // allocated_block [15:0], status [17:16], zero pad [23:18]
  output logic [23:0] m_axis_tdata
);
  import gbba_pkg::*;

  state_e state_q, state_d;

  logic        fdb_q;
  logic [16:0] bc_q;
  logic [13:0] bpg_q;
  logic [3:0]  gc_q;
  logic [15:0] ipg_q;

  logic [13:0] gfc_q [MAX_GROUPS];
  logic        gfc_we;
  logic [13:0] gfc_wd;
  logic [16:0] tfc_q, tfc_d;

  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 scan_we, scan_re;
  logic [ADDR_W-1:0]    scan_wa, scan_ra;
  logic [WORD_BITS-1:0] scan_wd;

  logic        func_q;
  logic [31:0] ino_q;
  logic [15:0] blk_q;

  logic [31:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        second_q, second_d;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [31:0] dq_step;
  logic [15:0] rem_step;

  logic [3:0]  g_q, g_d;
  logic [3:0]  pass_q, pass_d;
  logic        qbig_q, qbig_d;
  logic [13:0] r_q, r_d;
  logic [16:0] start_q, start_d;
  logic [13:0] vlim_q, vlim_d;
  logic [7:0]  nw_q, nw_d;
  logic [7:0]  w_rd_q, w_rd_d;
  logic        chk_v_q, chk_v_d;
  logic [6:0]  chk_w_q, chk_w_d;

  logic [15:0] res_blk_q, res_blk_d;
  status_e     res_st_q, res_st_d;
  logic        m_valid_q, m_valid_d;
  logic [15:0] out_blk_q, out_blk_d;
  status_e     out_st_q, out_st_d;

  // group geometry for g_q
  logic [17:0] prod, s_full, rest, n_full, room, vlim_full, nw_full;
  logic        gbad, sbad, nbad;
  logic [13:0] gfc_sel;
  logic [16:0] total;

  assign prod    = 18'(g_q) * 18'(bpg_q);
  assign s_full  = 18'(fdb_q) + prod;
  assign sbad    = s_full >= 18'(bc_q);
  assign rest    = 18'(bc_q) - s_full;
  assign n_full  = (18'(bpg_q) < rest) ? 18'(bpg_q) : rest;
  assign gbad    = g_q[3];
  assign nbad    = n_full > 18'(GROUP_BITS);
  assign room    = 18'(MAX_BLOCKS) - s_full;
  assign vlim_full = (s_full >= 18'(MAX_BLOCKS)) ? 18'd0 :
                     ((n_full < room) ? n_full : room);
  assign nw_full = n_full + 18'd63;
  assign gfc_sel = gfc_q[g_q[2:0]];
  assign total   = bc_q - 17'(fdb_q);

  // divider step
  assign rem_sh   = {rem_q, dq_q[31]};
  assign rem_ge   = rem_sh >= {1'b0, div_q};
  assign rem_step = rem_ge ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
  assign dq_step  = {dq_q[30:0], rem_ge};

  // word search
  logic signed [14:0]   lim;
  logic [WORD_BITS-1:0] okm, freev, onehot;
  logic [WIDX_W-1:0]    hidx;
  logic                 hit;
  logic [16:0]          cand;

  assign lim = $signed({1'b0, vlim_q}) - $signed({2'b00, chk_w_q, 6'b0});

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      okm[i] = lim > $signed(15'(i));
    end
  end

  assign freev  = ~mem_rdata_q & okm;
  assign onehot = freev & (~freev + 64'd1);
  assign hit    = |freev;

  always_comb begin
    hidx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        hidx = hidx | WIDX_W'(i);
      end
    end
  end

  assign cand = start_q + 17'({chk_w_q, hidx});

  assign s_axis_tready = (state_q == S_IDLE) && !clr_busy_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, out_st_q, out_blk_q};

  always_comb begin
    state_d   = state_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    second_d  = second_q;
    g_d       = g_q;
    pass_d    = pass_q;
    qbig_d    = qbig_q;
    r_d       = r_q;
    start_d   = start_q;
    vlim_d    = vlim_q;
    nw_d      = nw_q;
    w_rd_d    = w_rd_q;
    chk_v_d   = chk_v_q;
    chk_w_d   = chk_w_q;
    res_blk_d = res_blk_q;
    res_st_d  = res_st_q;
    tfc_d     = tfc_q;
    gfc_we    = 1'b0;
    gfc_wd    = gfc_sel;
    scan_we   = 1'b0;
    scan_wa   = '0;
    scan_wd   = mem_rdata_q;
    scan_re   = 1'b0;
    scan_ra   = '0;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_blk_d = out_blk_q;
    out_st_d  = out_st_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = S_START;
        end
      end
      S_START: begin
        res_blk_d = '0;
        rem_d     = '0;
        cnt_d     = '0;
        second_d  = 1'b0;
        if (func_q == FUNC_ALLOC) begin
          if (gc_q == '0 || bpg_q == '0 || ipg_q == '0 || bc_q <= 17'(fdb_q)) begin
            res_st_d = ST_NOFREE;
            state_d  = S_OUT;
          end else begin
            dq_d    = (ino_q == '0) ? 32'd0 : ino_q - 32'd1;
            div_d   = ipg_q;
            state_d = S_DIV;
          end
        end else begin
          if (gc_q == '0 || bpg_q == '0 || bc_q <= 17'(fdb_q) ||
              blk_q < 16'(fdb_q) || 17'(blk_q) >= bc_q) begin
            res_st_d = ST_REJECT;
            state_d  = S_OUT;
          end else begin
            dq_d    = 32'(blk_q - 16'(fdb_q));
            div_d   = 16'(bpg_q);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        dq_d  = dq_step;
        rem_d = rem_step;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          if (func_q == FUNC_ALLOC && !second_q) begin
            rem_d    = '0;
            div_d    = 16'(gc_q);
            second_d = 1'b1;
          end else if (func_q == FUNC_ALLOC) begin
            g_d     = rem_step[3:0];
            pass_d  = '0;
            state_d = S_GRP;
          end else begin
            g_d     = dq_step[3:0];
            qbig_d  = dq_step >= 32'(gc_q);
            r_d     = rem_step[13:0];
            state_d = S_FCHK;
          end
        end
      end
      S_GRP: begin
        if (gbad || sbad || nbad || 18'(gfc_sel) > n_full) begin
          res_st_d = ST_BAD;
          state_d  = S_OUT;
        end else if (gfc_sel == '0 || tfc_q == '0 || tfc_q > total) begin
          state_d = S_NXT;
        end else begin
          start_d = s_full[16:0];
          vlim_d  = vlim_full[13:0];
          nw_d    = nw_full[13:6];
          w_rd_d  = '0;
          chk_v_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_NXT: begin
        pass_d = pass_q + 4'd1;
        g_d    = (g_q + 4'd1 == gc_q) ? 4'd0 : g_q + 4'd1;
        if (pass_q + 4'd1 == gc_q) begin
          res_st_d = ST_NOFREE;
          state_d  = S_OUT;
        end else begin
          state_d = S_GRP;
        end
      end
      S_SCAN: begin
        chk_v_d = 1'b0;
        if (w_rd_q < nw_q) begin
          scan_re = 1'b1;
          scan_ra = {g_q[2:0], w_rd_q[6:0]};
          w_rd_d  = w_rd_q + 8'd1;
          chk_v_d = 1'b1;
          chk_w_d = w_rd_q[6:0];
        end
        if (chk_v_q) begin
          if (hit) begin
            scan_we   = 1'b1;
            scan_wa   = {g_q[2:0], chk_w_q};
            scan_wd   = mem_rdata_q | onehot;
            gfc_we    = 1'b1;
            gfc_wd    = gfc_sel - 14'd1;
            tfc_d     = tfc_q - 17'd1;
            res_blk_d = cand[15:0];
            res_st_d  = ST_DONE;
            state_d   = S_OUT;
          end else if (8'(chk_w_q) == nw_q - 8'd1) begin
            state_d = S_NXT;
          end
        end
      end
      S_FCHK: begin
        if (qbig_q || gbad || sbad || nbad || 18'(r_q) >= n_full ||
            18'(gfc_sel) >= n_full || tfc_q >= total) begin
          res_st_d = ST_REJECT;
          state_d  = S_OUT;
        end else begin
          scan_re = 1'b1;
          scan_ra = {g_q[2:0], r_q[12:6]};
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        if (mem_rdata_q[r_q[5:0]]) begin
          scan_we  = 1'b1;
          scan_wa  = {g_q[2:0], r_q[12:6]};
          scan_wd  = mem_rdata_q & ~(64'd1 << r_q[5:0]);
          gfc_we   = 1'b1;
          gfc_wd   = gfc_sel + 14'd1;
          tfc_d    = tfc_q + 17'd1;
          res_st_d = ST_DONE;
        end else begin
          res_st_d = ST_REJECT;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_blk_d = res_blk_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // bitmap memory ports, reset sweep has the write port
  assign mem_we = clr_busy_q || scan_we;
  assign mem_wa = clr_busy_q ? clr_cnt_q : scan_wa;
  assign mem_wd = clr_busy_q ? '1 : scan_wd;
  assign mem_re = scan_re;
  assign mem_ra = scan_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      tfc_q      <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        gfc_q[i] <= '0;
      end
      fdb_q <= 1'b1;
      bc_q  <= '0;
      bpg_q <= 14'd8192;
      gc_q  <= 4'd1;
      ipg_q <= 16'd2048;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      tfc_q     <= tfc_d;
      if (gfc_we) begin
        gfc_q[g_q[2:0]] <= gfc_wd;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST_DATA_BLOCK: fdb_q <= cfg_data_i[0];
          REG_BLOCKS_COUNT:     bc_q  <= cfg_data_i;
          REG_BLOCKS_PER_GROUP: bpg_q <= cfg_data_i[13:0];
          REG_GROUPS_COUNT:     gc_q  <= cfg_data_i[3:0];
          REG_INODES_PER_GROUP: ipg_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tuser;
      ino_q  <= s_axis_tdata[31:0];
      blk_q  <= s_axis_tdata[47:32];
    end
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    cnt_q     <= cnt_d;
    second_q  <= second_d;
    g_q       <= g_d;
    pass_q    <= pass_d;
    qbig_q    <= qbig_d;
    r_q       <= r_d;
    start_q   <= start_d;
    vlim_q    <= vlim_d;
    nw_q      <= nw_d;
    w_rd_q    <= w_rd_d;
    chk_v_q   <= chk_v_d;
    chk_w_q   <= chk_w_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    out_blk_q <= out_blk_d;
    out_st_q  <= out_st_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_no_input_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input taken during bitmap sweep");

  a_hit_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && chk_v_q && hit) |=> (state_q == S_OUT))
    else $error("found block did not end the search");

  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_we |-> (!clr_busy_q && (state_q == S_SCAN || state_q == S_FRD)))
    else $error("bitmap write outside update states");

endmodule
